[rtl/half_step_stepper_sequencer_macros.svh]
// Assertion macros for the half-step stepper sequencer.
// Used by the top level; the macros expect clk and rst_n in scope.
`ifndef HALF_STEP_STEPPER_SEQUENCER_MACROS_SVH
`define HALF_STEP_STEPPER_SEQUENCER_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising edge outside reset.
`define HSS_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hss: assertion failed");
// Next-cycle implication, checked at every rising edge outside reset.
`define HSS_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hss: assertion failed");
`else
`define HSS_ASSERT_IMP(label, ante, cons)
`define HSS_ASSERT_NXT(label, ante, cons)
`endif
`endif

[rtl/hss_pkg.sv]
// Package for the half-step stepper sequencer: request and response types,
// operation codes, the half-step pattern table and the step count helper.
// No dependencies.
`default_nettype none

package hss_pkg;

    localparam int OP_W       = 2;
    localparam int ANGLE_W    = 13;
    localparam int INTERVAL_W = 16;
    localparam int COUNT_W    = 16;
    localparam int PHASE_W    = 3;
    localparam int COIL_W     = 4;

    localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
    localparam logic [OP_W-1:0] OP_START = 2'd1;
    localparam logic [OP_W-1:0] OP_STOP  = 2'd2;

    // floor(angle * 64 / 45) == (angle * DIV_MUL) >> DIV_SHIFT, exact for 13-bit angles.
    localparam int DIV_MUL_W = 20;
    localparam logic [DIV_MUL_W-1:0] DIV_MUL = 20'd745655;
    localparam int DIV_SHIFT  = 19;
    localparam int PROD_W     = ANGLE_W + DIV_MUL_W;
    localparam int QUOT_W     = PROD_W - DIV_SHIFT;
    localparam int HALF_STEPS = 3;   // each whole step is eight half steps

    typedef struct packed {
        logic [OP_W-1:0]       op;
        logic                  direction;
        logic [ANGLE_W-1:0]    angle_deg;
        logic [INTERVAL_W-1:0] interval_ticks;
    } req_t;

    typedef struct packed {
        logic [COIL_W-1:0] coils;
        logic              busy_res;
    } rsp_t;

    // Coil pattern per table index: A, A+B, B, B+C, C, C+D, D, A+D.
    function automatic logic [COIL_W-1:0] half_step_pattern(input logic [PHASE_W-1:0] idx);
        logic [COIL_W-1:0] pat;
        unique case (idx)
            3'd0: pat = 4'h1;
            3'd1: pat = 4'h3;
            3'd2: pat = 4'h2;
            3'd3: pat = 4'h6;
            3'd4: pat = 4'h4;
            3'd5: pat = 4'hC;
            3'd6: pat = 4'h8;
            default: pat = 4'h9;
        endcase
        return pat;
    endfunction

    // Half-step count for a move, saturated to the counter width.
    function automatic logic [COUNT_W-1:0] steps_from_angle(input logic [ANGLE_W-1:0] angle);
        logic [PROD_W-1:0] prod;
        logic [QUOT_W-1:0] quot;
        prod = PROD_W'(angle) * PROD_W'(DIV_MUL);
        quot = prod[PROD_W-1:DIV_SHIFT];
        if (quot[QUOT_W-1:COUNT_W-HALF_STEPS] != '0)
        begin
            return '1;
        end
        return {quot[COUNT_W-HALF_STEPS-1:0], {HALF_STEPS{1'b0}}};
    endfunction

endpackage

`default_nettype wire

[rtl/half_step_stepper_sequencer.sv]
// Half-step stepper sequencer for a four-coil unipolar motor.
// Depends on hss_pkg and half_step_stepper_sequencer_macros.svh.
// Every request (tick, start, stop or an unused op) gives one response carrying the coil
// levels and the busy flag after that request has taken effect. A request is captured
// in an input register and, once the output register is free or draining, worked on
// by one pass of logic whose only wide part is the 13 by 20 bit multiply that turns
// the angle into a half-step count; the response then sits in an output register.
// Throughput is one request per clock while the response side keeps up; a request
// is still taken while a response waits, as long as the input register is empty.
`default_nettype none
`include "half_step_stepper_sequencer_macros.svh"

module half_step_stepper_sequencer
    import hss_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic req_valid,
    output logic      req_ready,
    input  wire req_t req,
    output logic      rsp_valid,
    input  wire logic rsp_ready,
    output rsp_t      rsp
);

    logic                  req_valid_reg;
    req_t                  req_reg;
    logic                  rsp_valid_reg;
    rsp_t                  rsp_reg;
    logic                  advance;

    logic                  running_reg,  running_next;
    logic                  dir_reg,      dir_next;
    logic [PHASE_W-1:0]    phase_reg,    phase_next;
    logic [COUNT_W-1:0]    steps_reg,    steps_next;
    logic [INTERVAL_W-1:0] interval_reg, interval_next;
    logic [INTERVAL_W-1:0] elapsed_reg,  elapsed_next;
    logic [COIL_W-1:0]     coil_reg,     coil_next;
    logic [INTERVAL_W-1:0] elapsed_inc;
    logic [PHASE_W-1:0]    table_idx;

    // The working stage moves on when the output register is free or draining.
    assign advance   = req_valid_reg && (!rsp_valid_reg || rsp_ready);
    assign req_ready = !req_valid_reg || advance;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign elapsed_inc = (elapsed_reg == '1) ? elapsed_reg : elapsed_reg + 1'b1;
    assign table_idx   = dir_reg ? phase_reg : ~phase_reg;

    always_comb
    begin
        running_next  = running_reg;
        dir_next      = dir_reg;
        phase_next    = phase_reg;
        steps_next    = steps_reg;
        interval_next = interval_reg;
        elapsed_next  = elapsed_reg;
        coil_next     = coil_reg;
        unique case (req_reg.op)
            OP_TICK:
            begin
                if (running_reg)
                begin
                    if (elapsed_inc < interval_reg)
                    begin
                        elapsed_next = elapsed_inc;
                    end
                    else
                    begin
                        elapsed_next = '0;
                        // A due tick with no steps left, or the last step, ends the move.
                        if (steps_reg == '0 || steps_reg == COUNT_W'(1))
                        begin
                            running_next = 1'b0;
                            phase_next   = '0;
                            steps_next   = '0;
                            coil_next    = '0;
                        end
                        else
                        begin
                            coil_next  = half_step_pattern(table_idx);
                            phase_next = phase_reg + 1'b1;
                            steps_next = steps_reg - 1'b1;
                        end
                    end
                end
            end
            OP_START:
            begin
                if (!running_reg)
                begin
                    running_next  = 1'b1;
                    dir_next      = req_reg.direction;
                    phase_next    = '0;
                    steps_next    = steps_from_angle(req_reg.angle_deg);
                    interval_next = (req_reg.interval_ticks == '0) ? INTERVAL_W'(1)
                                                                   : req_reg.interval_ticks;
                    elapsed_next  = '0;
                end
            end
            OP_STOP:
            begin
                running_next = 1'b0;
                phase_next   = '0;
                steps_next   = '0;
                coil_next    = '0;
            end
            default:
            begin
                running_next = running_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
            running_reg   <= 1'b0;
            dir_reg       <= 1'b0;
            phase_reg     <= '0;
            steps_reg     <= '0;
            interval_reg  <= '0;
            elapsed_reg   <= '0;
            coil_reg      <= '0;
        end
        else
        begin
            if (req_ready)
            begin
                req_valid_reg <= req_valid;
            end
            if (advance)
            begin
                rsp_valid_reg <= 1'b1;
                running_reg   <= running_next;
                dir_reg       <= dir_next;
                phase_reg     <= phase_next;
                steps_reg     <= steps_next;
                interval_reg  <= interval_next;
                elapsed_reg   <= elapsed_next;
                coil_reg      <= coil_next;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
        begin
            req_reg <= req;
        end
        if (advance)
        begin
            rsp_reg.coils    <= coil_next;
            rsp_reg.busy_res <= running_next;
        end
    end

    `HSS_ASSERT_IMP(a_idle_coils_off, !running_reg, coil_reg == '0)
    `HSS_ASSERT_IMP(a_interval_set, running_reg, interval_reg != '0)
    `HSS_ASSERT_IMP(a_elapsed_below, running_reg, elapsed_reg < interval_reg)
    `HSS_ASSERT_NXT(a_rsp_follows, advance, rsp_valid_reg && rsp_reg.busy_res == running_reg)

endmodule

`default_nettype wire

[tb/hss_checker.sv]
`timescale 1ns / 1ps
// Checker for the half-step stepper sequencer: watches both channels, predicts each
// response from the accepted requests and compares them in order. Depends on hss_pkg.
module hss_checker
    import hss_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    input  logic req_ready,
    input  req_t req,
    input  logic rsp_valid,
    input  logic rsp_ready,
    input  rsp_t rsp,
    output int   mismatches,
    output int   outstanding
);

    // Half-step coil patterns, entry 0 in the low nibble: A, A+B, B, B+C, C, C+D, D, A+D.
    localparam logic [8*COIL_W-1:0] COIL_SEQ = {4'h9, 4'h8, 4'hC, 4'h4, 4'h6, 4'h2, 4'h3, 4'h1};

    logic                  moving;
    logic                  forward;
    logic [PHASE_W-1:0]    phase;
    logic [COUNT_W-1:0]    steps_left;
    logic [INTERVAL_W-1:0] period;
    logic [INTERVAL_W-1:0] elapsed;
    logic [COIL_W-1:0]     coil_drive;

    rsp_t expected_rsp_q[$];
    rsp_t want;
    int   fail_count;

    function automatic void motor_off();
        coil_drive = '0;
        moving     = 1'b0;
        phase      = '0;
        steps_left = '0;
    endfunction

    function automatic rsp_t motor_response(input req_t r);
        logic [31:0]        count;
        logic [PHASE_W-1:0] idx;
        rsp_t               res;
        case (r.op)
            OP_TICK:
            begin
                if (moving)
                begin
                    if (elapsed != '1)
                        elapsed = elapsed + 1'b1;
                    if (elapsed >= period)
                    begin
                        elapsed = '0;
                        if (steps_left == '0)
                            motor_off();
                        else
                        begin
                            idx        = forward ? phase : 3'd7 - phase;
                            coil_drive = COIL_SEQ[{idx, 2'b00} +: COIL_W];
                            phase      = phase + 1'b1;
                            steps_left = steps_left - 1'b1;
                            // The final step turns the coils off in the same request.
                            if (steps_left == '0)
                                motor_off();
                        end
                    end
                end
            end
            OP_START:
            begin
                if (!moving)
                begin
                    forward    = r.direction;
                    count      = ((32'(r.angle_deg) * 32'd64) / 32'd45) * 32'd8;
                    steps_left = (count > 32'hFFFF) ? 16'hFFFF : count[COUNT_W-1:0];
                    phase      = '0;
                    period     = (r.interval_ticks == '0) ? 16'd1 : r.interval_ticks;
                    elapsed    = '0;
                    moving     = 1'b1;
                end
            end
            OP_STOP:
                motor_off();
            default:
                ;
        endcase
        res.coils    = coil_drive;
        res.busy_res = moving;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            moving      = 1'b0;
            forward     = 1'b0;
            phase       = '0;
            steps_left  = '0;
            period      = '0;
            elapsed     = '0;
            coil_drive  = '0;
            fail_count  = 0;
            expected_rsp_q.delete();
            mismatches  <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (req_valid && req_ready)
                expected_rsp_q.push_back(motor_response(req));
            if (rsp_valid && rsp_ready)
            begin
                if (expected_rsp_q.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: response with no request waiting: expected none, got coils %h busy %b",
                             $time, rsp.coils, rsp.busy_res);
                end
                else
                begin
                    want = expected_rsp_q.pop_front();
                    if (rsp.coils !== want.coils)
                    begin
                        fail_count++;
                        $display("%0t: coils mismatch: expected %h, got %h",
                                 $time, want.coils, rsp.coils);
                    end
                    if (rsp.busy_res !== want.busy_res)
                    begin
                        fail_count++;
                        $display("%0t: busy_res mismatch: expected %b, got %b",
                                 $time, want.busy_res, rsp.busy_res);
                    end
                end
            end
            outstanding <= expected_rsp_q.size();
            mismatches  <= fail_count;
        end
    end

endmodule

[tb/tb_half_step_stepper_sequencer.sv]
`timescale 1ns / 1ps
// Top of the half-step stepper sequencer testbench: clock, reset, request and response
// traffic, and the verdict. Depends on hss_pkg, the sequencer and hss_checker.
module tb_half_step_stepper_sequencer;
    import hss_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int              ITEM_GOAL = 1025;
    localparam int              RUN_LIMIT_NS = 5_000_000;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic rsp_ready = 1'b0;
    req_t req_data  = '0;
    logic req_ready;
    logic rsp_valid;
    rsp_t rsp_data;
    int   mismatches;
    int   outstanding;
    int   sent      = 0;
    bit   req_calm  = 1'b0;

    half_step_stepper_sequencer DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req_data),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp_data)
    );

    hss_checker checker_inst
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .req         (req_data),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .rsp         (rsp_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #(RUN_LIMIT_NS);
        $display("[half_step_stepper_sequencer] ERROR");
        $finish;
    end

    // Valid is only lowered when a gap follows, so back-to-back requests keep it high.
    task automatic issue(input logic [OP_W-1:0] op, input logic dir,
                         input logic [ANGLE_W-1:0] angle, input logic [INTERVAL_W-1:0] ival);
        req_t r;
        int   gap;
        r.op             = op;
        r.direction      = dir;
        r.angle_deg      = angle;
        r.interval_ticks = ival;
        gap = req_calm ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_data  <= r;
        @(posedge clk);
        while (!req_ready) @(posedge clk);
        sent++;
    endtask

    task automatic issue_op(input logic [OP_W-1:0] op);
        issue(op, 1'($urandom), 13'($urandom), 16'($urandom));
    endtask

    // Response side: random stalls, calm stretches, and one long hold that backs up requests.
    initial
    begin
        int gap;
        int taken;
        bit calm;
        taken = 0;
        calm  = 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 31) == 0)
                calm = !calm;
            gap = calm ? 0 : $urandom_range(0, 7);
            if (taken == 400)
                gap = 80;
            if (gap > 0)
            begin
                rsp_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            rsp_ready <= 1'b1;
            @(posedge clk);
            while (!rsp_valid) @(posedge clk);
            taken++;
        end
    end

    initial
    begin
        int                    kind;
        int                    steps;
        int                    n;
        logic [ANGLE_W-1:0]    angle;
        logic [INTERVAL_W-1:0] ival;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        issue_op(OP_TICK);                        // tick while idle
        issue(OP_STOP, 1'b1, '1, '1);             // stop while idle
        issue(OP_UNUSED, 1'b1, '1, '1);
        issue(OP_START, 1'b1, '0, '0);            // zero angle, zero interval taken as one
        issue_op(OP_TICK);
        issue(OP_START, 1'b0, '1, '1);            // count saturates, longest interval
        issue(OP_START, 1'b1, 13'd1, 16'd1);      // ignored while busy
        repeat (2) issue_op(OP_TICK);
        issue(OP_STOP, 1'b0, '0, '0);
        issue(OP_START, 1'b1, 13'd1, 16'd0);      // eight half steps through the whole table
        repeat (8) issue_op(OP_TICK);
        issue(OP_START, 1'b0, 13'd5759, 16'd2);   // largest angle that fits unsaturated
        repeat (4) issue_op(OP_TICK);
        issue_op(OP_STOP);

        while (sent < ITEM_GOAL)
        begin
            if ($urandom_range(0, 3) == 0)
                req_calm = !req_calm;
            kind = $urandom_range(0, 9);
            if (kind <= 6)
            begin
                // Complete move with small sizes, sometimes cut short by a stop.
                angle = 13'($urandom_range(0, 3));
                ival  = 16'($urandom_range(0, 3));
                steps = ((angle * 64) / 45) * 8;
                n = ((steps == 0) ? 1 : steps) * ((ival == 0) ? 1 : ival);
                if ($urandom_range(0, 3) == 0)
                    n = $urandom_range(0, n);
                issue(OP_START, 1'($urandom), angle, ival);
                repeat (n)
                begin
                    if ($urandom_range(0, 7) == 0)
                        issue_op($urandom_range(0, 1) ? OP_START : OP_UNUSED);
                    issue_op(OP_TICK);
                end
                issue_op(OP_STOP);
            end
            else if (kind == 7)
            begin
                ival = $urandom_range(0, 1) ? 16'($urandom_range(0, 2)) : 16'($urandom);
                issue(OP_START, 1'($urandom), 13'($urandom_range(0, 8191)), ival);
                repeat ($urandom_range(0, 20)) issue_op(OP_TICK);
                issue_op(OP_STOP);
            end
            else if (kind == 8)
            begin
                repeat ($urandom_range(1, 5)) issue_op(2'($urandom_range(0, 3)));
                issue_op(OP_STOP);
            end
            else
            begin
                issue_op($urandom_range(0, 1) ? OP_TICK : OP_STOP);
            end
        end
        req_valid <= 1'b0;

        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("[half_step_stepper_sequencer] OK");
        else
            $display("[half_step_stepper_sequencer] ERROR");
        $finish;
    end

endmodule
